// ===== src/pfe_pkg.sv =====
// Shared types, frame constants and the CRC-8 byte update for the pedal frame encoder.
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

  // Frame layout.
  localparam int unsigned FRAME_LEN = 12;
  localparam int unsigned IDX_W = $clog2(FRAME_LEN);

  localparam logic [7:0] FRAME_START = 8'h7B;
  localparam logic [7:0] FRAME_CMD   = 8'h01;
  localparam logic [7:0] FRAME_END   = 8'h7D;

  // CRC settings.
  localparam logic [7:0] CRC_RESET_POLY = 8'h8C;
  localparam logic [7:0] CRC_INIT       = 8'hFF;

  // Byte positions inside the frame.
  localparam logic [IDX_W-1:0] POS_START = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_CMD   = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_THR_L = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_THR_H = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_BRK_L = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_BRK_H = IDX_W'(5);
  localparam logic [IDX_W-1:0] POS_CLU_L = IDX_W'(6);
  localparam logic [IDX_W-1:0] POS_CLU_H = IDX_W'(7);
  localparam logic [IDX_W-1:0] POS_HBK_L = IDX_W'(8);
  localparam logic [IDX_W-1:0] POS_HBK_H = IDX_W'(9);
  localparam logic [IDX_W-1:0] POS_CRC   = IDX_W'(10);
  localparam logic [IDX_W-1:0] POS_END   = IDX_W'(11);

  // Default depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0] throttle_value;
    logic [15:0] brake_value;
    logic [15:0] clutch_value;
    logic [15:0] handbrake_value;
  } pedal_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_out_t;

  // One byte of a reflected CRC-8: XOR the byte in, then eight LSB-first shifts.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/pfe_queue.sv =====
// Small flip-flop queue that holds accepted pedal beats ahead of the frame serializer.
`timescale 1ns / 1ps
`default_nettype none

module pfe_queue
  import pfe_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  input  wire pedal_in_t push_data_i,
  output logic           pop_valid_o,
  input  wire logic      pop_ready_i,
  output pedal_in_t      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  pedal_in_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The fill count never runs past the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntFull)
    else $error("queue count exceeds depth");

  // Pointers and count move together: equal pointers mean empty or full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q == rd_ptr_q) |-> (count_q == '0 || count_q == CntFull))
    else $error("queue pointers disagree with count");

  // A push without a pop grows the count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count did not grow on push");

endmodule

`default_nettype wire

// ===== src/pfe_back.sv =====
// Frame serializer: walks one pedal beat through its twelve frame bytes and builds the CRC.
`timescale 1ns / 1ps
`default_nettype none

module pfe_back
  import pfe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] poly_i,
  input  wire logic       item_valid_i,
  output logic            item_ready_o,
  input  wire pedal_in_t  item_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output frame_out_t      out_data_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       crc_q, crc_d;
  logic             out_valid_q, out_valid_d;
  frame_out_t       out_q, out_d;
  logic [7:0]       cur_byte;
  logic             load;

  // A new byte moves into the output register when it is empty or being drained.
  assign load         = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_ready_o = load && (idx_q == POS_END);

  always_comb begin
    case (idx_q)
      POS_START: cur_byte = FRAME_START;
      POS_CMD:   cur_byte = FRAME_CMD;
      POS_THR_L: cur_byte = item_i.throttle_value[7:0];
      POS_THR_H: cur_byte = item_i.throttle_value[15:8];
      POS_BRK_L: cur_byte = item_i.brake_value[7:0];
      POS_BRK_H: cur_byte = item_i.brake_value[15:8];
      POS_CLU_L: cur_byte = item_i.clutch_value[7:0];
      POS_CLU_H: cur_byte = item_i.clutch_value[15:8];
      POS_HBK_L: cur_byte = item_i.handbrake_value[7:0];
      POS_HBK_H: cur_byte = item_i.handbrake_value[15:8];
      POS_CRC:   cur_byte = crc_q;
      POS_END:   cur_byte = FRAME_END;
      default:   cur_byte = '0;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      idx_d            = (idx_q == POS_END) ? POS_START : idx_q + IDX_W'(1);
      out_d.frame_byte = cur_byte;
      out_d.last_byte  = (idx_q == POS_END);
      out_valid_d      = 1'b1;
      // The check covers the command byte and the eight pedal bytes.
      if (idx_q == POS_START) begin
        crc_d = CRC_INIT;
      end else if (idx_q < POS_CRC) begin
        crc_d = crc8_update(crc_q, cur_byte, poly_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= POS_START;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The byte position never leaves the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni) idx_q <= POS_END)
    else $error("byte position out of frame");

  // A marked byte is always the end marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last_byte) |-> out_q.frame_byte == FRAME_END)
    else $error("last byte is not the end marker");

  // Loading the first position puts the start byte on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && idx_q == POS_START) |=> (out_valid_q && out_q.frame_byte == FRAME_START))
    else $error("frame did not open with the start byte");

endmodule

`default_nettype wire

// ===== src/pedal_frame_encoder_crc8_unit.sv =====
// Top level of the pedal frame encoder: config register, input queue and frame serializer.
// Throughput: one frame byte per cycle while out_ready_i holds and a pedal beat waits,
// set by the serializer that emits the twelve bytes of a frame through a single output
// register. An accepted pedal beat is written into the queue, and its frame bytes then
// move in order through the output register.
// Reset (rst_ni, asynchronous, active low) empties the queue and the output register
// and sets the CRC polynomial to 0x8C.
`timescale 1ns / 1ps
`default_nettype none

module pedal_frame_encoder_crc8_unit
  import pfe_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Pedal beats in.
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire pedal_in_t  in_data_i,
  // Frame bytes out, twelve per pedal beat.
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output frame_out_t      out_data_o,
  // Polynomial write channel.
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  // The polynomial register is always writable. Writes must come only while the block is
  // idle (the block does not enforce it), so the serializer reads it with no shadow copy.
  logic [7:0] poly_q, poly_d;

  assign cfg_ready_o = 1'b1;
  assign poly_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : poly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= CRC_RESET_POLY;
    end else begin
      poly_q <= poly_d;
    end
  end

  // Front side: accepted pedal beats wait in a short queue, so a new set of values can be
  // taken while the serializer is still busy with the previous frame.
  pedal_in_t q_data;
  logic      q_valid;
  logic      q_ready;

  pfe_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(in_valid_i),
    .push_ready_o(in_ready_o),
    .push_data_i (in_data_i),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_data)
  );

  // Back side: the head of the queue stays in place for the whole frame and is released
  // when its end byte moves into the output register.
  pfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .poly_i      (poly_q),
    .item_valid_i(q_valid),
    .item_ready_o(q_ready),
    .item_i      (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
